@@ hw/rtl/itoa_pkg.sv @@
`timescale 1ns / 1ps

package itoa_pkg;

  // Default operand width of the converter.
  localparam int VALUE_WIDTH_DEF = 32;

  // Binary bits folded into the decimal word by one conversion stage.
  localparam int DD_BITS = 4;

  // Width of one output character code.
  localparam int CHAR_W = 6;

  typedef logic [CHAR_W-1:0] char_t;

  // Character codes of the decimal text.
  localparam char_t CHAR_ZERO  = 6'd48;
  localparam char_t CHAR_MINUS = 6'd45;

endpackage

@@ hw/rtl/itoa_mag.sv @@
`timescale 1ns / 1ps

module itoa_mag import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic                   neg_o,
  output logic [VALUE_WIDTH-1:0] mag_o
);

  logic                   valid_q;
  logic                   neg_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [VALUE_WIDTH-1:0] mag_d;

  // The stage takes a new item whenever it is empty or its item moves on.
  assign ready_o = !valid_q || ready_i;

  // Unsigned magnitude; the most negative value maps onto itself, which is
  // exactly its magnitude read as unsigned.
  assign mag_d = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      neg_q <= value_i[VALUE_WIDTH-1];
      mag_q <= mag_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign mag_o   = mag_q;

endmodule

@@ hw/rtl/itoa_dd_stage.sv @@
`timescale 1ns / 1ps

module itoa_dd_stage import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = 10,
  parameter int STEP_BITS   = DD_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic                    neg_i,
  input  logic [VALUE_WIDTH-1:0]  bin_i,
  input  logic [NUM_DIGITS*4-1:0] bcd_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic                    neg_o,
  output logic [VALUE_WIDTH-1:0]  bin_o,
  output logic [NUM_DIGITS*4-1:0] bcd_o
);

  logic                    valid_q;
  logic                    neg_q;
  logic [VALUE_WIDTH-1:0]  bin_q;
  logic [NUM_DIGITS*4-1:0] bcd_q;
  logic [VALUE_WIDTH-1:0]  bin_d;
  logic [NUM_DIGITS*4-1:0] bcd_d;

  assign ready_o = !valid_q || ready_i;

  // Shift-and-add-3: each step corrects every decimal digit of five or more,
  // then shifts the next binary bit in at the bottom of the decimal word.
  always_comb begin
    bin_d = bin_i;
    bcd_d = bcd_i;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_d[d*4 +: 4] >= 4'd5) begin
          bcd_d[d*4 +: 4] = bcd_d[d*4 +: 4] + 4'd3;
        end
      end
      bcd_d = {bcd_d[NUM_DIGITS*4-2:0], bin_d[VALUE_WIDTH-1]};
      bin_d = {bin_d[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      neg_q <= neg_i;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;

endmodule

@@ hw/rtl/itoa_lead.sv @@
`timescale 1ns / 1ps

module itoa_lead import itoa_pkg::*; #(
  parameter int NUM_DIGITS = 10,
  parameter int POS_W      = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic                    neg_i,
  input  logic [NUM_DIGITS*4-1:0] bcd_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic                    neg_o,
  output logic [NUM_DIGITS*4-1:0] bcd_o,
  output logic [POS_W-1:0]        top_o
);

  logic                    valid_q;
  logic                    neg_q;
  logic [NUM_DIGITS*4-1:0] bcd_q;
  logic [POS_W-1:0]        top_q;
  logic [POS_W-1:0]        top_d;

  assign ready_o = !valid_q || ready_i;

  // Index of the most significant nonzero digit; zero keeps one digit.
  always_comb begin
    top_d = '0;
    for (int d = 1; d < NUM_DIGITS; d++) begin
      if (bcd_i[d*4 +: 4] != 4'd0) begin
        top_d = POS_W'(d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      neg_q <= neg_i;
      bcd_q <= bcd_i;
      top_q <= top_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bcd_o   = bcd_q;
  assign top_o   = top_q;

endmodule

@@ hw/rtl/itoa_ser.sv @@
`timescale 1ns / 1ps

module itoa_ser import itoa_pkg::*; #(
  parameter int NUM_DIGITS = 10,
  parameter int POS_W      = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic                    neg_i,
  input  logic [NUM_DIGITS*4-1:0] bcd_i,
  input  logic [POS_W-1:0]        top_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output char_t                   character_o,
  output logic                    last_o
);

  logic                    busy_q;
  logic                    sign_q;
  logic [POS_W-1:0]        pos_q;
  logic [NUM_DIGITS*4-1:0] bcd_q;
  logic                    out_valid_q;
  char_t                   char_q;
  logic                    last_q;

  logic                    adv;
  logic                    have;
  logic                    emit;
  logic                    cur_sign;
  logic [POS_W-1:0]        cur_pos;
  logic [NUM_DIGITS*4-1:0] cur_bcd;
  logic [3:0]              digit;
  char_t                   char_d;
  logic                    last_d;

  // The output register can load when it is empty or being taken.
  assign adv  = !out_valid_q || !out_stall_i;
  assign have = busy_q || valid_i;
  assign emit = adv && have;

  // A new item is emitted straight from the input, so items follow
  // one another without a gap character slot.
  assign cur_sign = busy_q ? sign_q : neg_i;
  assign cur_pos  = busy_q ? pos_q  : top_i;
  assign cur_bcd  = busy_q ? bcd_q  : bcd_i;
  assign digit    = cur_bcd[cur_pos*4 +: 4];
  assign ready_o  = !busy_q && adv;

  // Minus sign first, then digits from the most significant down.
  always_comb begin
    if (cur_sign) begin
      char_d = CHAR_MINUS;
      last_d = 1'b0;
    end else begin
      char_d = CHAR_ZERO + char_t'(digit);
      last_d = (cur_pos == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        busy_q <= !last_d;
        sign_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= have;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pos_q  <= cur_sign ? cur_pos : cur_pos - POS_W'(1);
      bcd_q  <= cur_bcd;
      char_q <= char_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps
// Registered stages, in order: sign and magnitude, the shift-and-add-3 stages,
// leading-digit search, and the character output register.
// Throughput: one character per cycle while out_stall_i is low; an item holds
// the output for its digit count plus one for a minus sign (1 to 11 characters at 32 bits), back to back.
// Reset (rst_ni, asynchronous, active low) empties every stage; no state is kept.
module signed_int_to_decimal_ascii_core import itoa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output char_t                  character_o,
  output logic                   last_o
);

  localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int PosW      = $clog2(NumDigits);
  localparam int NumStages = (VALUE_WIDTH + DD_BITS - 1) / DD_BITS;

  logic                   in_ready;
  logic                   valid_s [NumStages+1];
  logic                   ready_s [NumStages+1];
  logic                   neg_s   [NumStages+1];
  logic [NumDigits*4-1:0] bcd_s   [NumStages+1];
  logic [VALUE_WIDTH-1:0] bin_s   [NumStages];
  logic                   lead_valid;
  logic                   lead_ready;
  logic                   lead_neg;
  logic [NumDigits*4-1:0] lead_bcd;
  logic [PosW-1:0]        lead_top;

  assign in_stall_o = !in_ready;

  // Sign and magnitude.
  itoa_mag #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .value_i (value_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .neg_o   (neg_s[0]),
    .mag_o   (bin_s[0])
  );

  assign bcd_s[0] = '0;

  // Binary to decimal, DD_BITS bits per stage (fewer in the last if VALUE_WIDTH is not a multiple).
  for (genvar s = 0; s < NumStages; s++) begin : g_dd
    localparam int Rem  = VALUE_WIDTH - s * DD_BITS;
    localparam int Step = (Rem < DD_BITS) ? Rem : DD_BITS;
    if (s == NumStages - 1) begin : g_last
      itoa_dd_stage #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .NUM_DIGITS (NumDigits),
        .STEP_BITS  (Step)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (valid_s[s]),
        .ready_o (ready_s[s]),
        .neg_i   (neg_s[s]),
        .bin_i   (bin_s[s]),
        .bcd_i   (bcd_s[s]),
        .valid_o (valid_s[s+1]),
        .ready_i (ready_s[s+1]),
        .neg_o   (neg_s[s+1]),
        .bin_o   (),
        .bcd_o   (bcd_s[s+1])
      );
    end else begin : g_mid
      itoa_dd_stage #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .NUM_DIGITS (NumDigits),
        .STEP_BITS  (Step)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (valid_s[s]),
        .ready_o (ready_s[s]),
        .neg_i   (neg_s[s]),
        .bin_i   (bin_s[s]),
        .bcd_i   (bcd_s[s]),
        .valid_o (valid_s[s+1]),
        .ready_i (ready_s[s+1]),
        .neg_o   (neg_s[s+1]),
        .bin_o   (bin_s[s+1]),
        .bcd_o   (bcd_s[s+1])
      );
    end
  end

  // Leading digit position.
  itoa_lead #(
    .NUM_DIGITS(NumDigits),
    .POS_W     (PosW)
  ) u_lead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NumStages]),
    .ready_o (ready_s[NumStages]),
    .neg_i   (neg_s[NumStages]),
    .bcd_i   (bcd_s[NumStages]),
    .valid_o (lead_valid),
    .ready_i (lead_ready),
    .neg_o   (lead_neg),
    .bcd_o   (lead_bcd),
    .top_o   (lead_top)
  );

  // Character serializer and output register.
  itoa_ser #(
    .NUM_DIGITS(NumDigits),
    .POS_W     (PosW)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (lead_valid),
    .ready_o     (lead_ready),
    .neg_i       (lead_neg),
    .bcd_i       (lead_bcd),
    .top_i       (lead_top),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // Only a minus sign or a decimal digit ever leaves the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CHAR_MINUS) ||
                    ((character_o >= CHAR_ZERO) && (character_o <= CHAR_ZERO + char_t'(9))))
    else $error("character outside the decimal alphabet");

  // The final character of a number is always a digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (character_o != CHAR_MINUS))
    else $error("minus sign flagged as last character");

  // A minus sign that is taken is followed by a digit, never another sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && (character_o == CHAR_MINUS)) |=>
    (out_valid_o && (character_o != CHAR_MINUS)))
    else $error("minus sign not followed by a digit");

endmodule

@@ verif/signed_int_to_decimal_ascii_core_tb.sv @@
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_tb;
  import itoa_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int RANDOM_NUMBERS = 200;

  // One character of decimal text as the block should emit it.
  typedef struct packed {
    char_t code;
    logic  last;
  } text_char_t;

  // Receiver behavior; each mode holds for a random stretch of cycles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  logic [VW-1:0] value_i     = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  char_t         character_o;
  logic          last_o;

  logic [VW-1:0] pending_values[$];
  text_char_t    expected_text[$];

  int unsigned pow10[10] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
                             100000000, 1000000000};

  int          burst_left = 0;
  int          gap_left   = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int unsigned cyc        = 0;

  int numbers_sent    = 0;
  int negatives_sent  = 0;
  int longest_text    = 0;
  int chars_checked   = 0;
  int mismatch_count  = 0;

  signed_int_to_decimal_ascii_core #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Work out the decimal text of one number and queue its characters.
  function automatic void predict_text(logic [VW-1:0] num);
    logic          neg;
    logic [VW-1:0] mag;
    char_t         digits[$];
    text_char_t    tc;
    int            len;
    neg = num[VW-1];
    mag = neg ? (~num + 1'b1) : num;
    // The magnitude is unsigned, so the most negative value needs no special path.
    do begin
      digits.push_front(CHAR_ZERO + char_t'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    len = digits.size() + (neg ? 1 : 0);
    if (neg) begin
      tc.code = CHAR_MINUS;
      tc.last = 1'b0;
      expected_text.push_back(tc);
      negatives_sent++;
    end
    foreach (digits[i]) begin
      tc.code = digits[i];
      tc.last = (i == digits.size() - 1);
      expected_text.push_back(tc);
    end
    if (len > longest_text) longest_text = len;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Sender: bursts of random length separated by random gaps; a stalled item is held.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_text(value_i);
        numbers_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_values.size() != 0) begin
          in_valid_i <= 1'b1;
          value_i    <= pending_values.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall behavior switches between modes every so often.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= STALL_NONE;
      mode_left   <= 0;
      cyc         <= 0;
    end else begin
      cyc <= cyc + 1;
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall_i <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall_i <= ($urandom_range(0, 2) == 0);
        end
        STALL_PERIODIC: begin
          out_stall_i <= ((cyc % 7) >= 4);
        end
        default: begin
          out_stall_i <= ($urandom_range(0, 9) < 8);
        end
      endcase
    end
  end

  // Compare each accepted character with the oldest expected one.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        note_mismatch($sformatf("unexpected character %0d last %0d", character_o, last_o));
      end else begin
        want = expected_text.pop_front();
        if (character_o !== want.code || last_o !== want.last) begin
          note_mismatch($sformatf("character exp %0d got %0d, last exp %0d got %0d",
                                  want.code, character_o, want.last, last_o));
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [VW-1:0] num;
    int unsigned   mag;
    int            d;
    // Directed: extremes, sign boundaries and texts of 1 to 3 and 9 to 11 characters.
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(-32'sd99);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'd123456789);
    pending_values.push_back(-32'sd123456789);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(-32'sd7);
    pending_values.push_back(32'd1234567890);
    // Random numbers, spread over text lengths and close to powers of ten.
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      case ($urandom_range(0, 3))
        0: begin
          num = $urandom;
        end
        1: begin
          mag = $urandom_range(0, 999);
          num = $urandom_range(0, 1) ? -mag : mag;
        end
        2: begin
          d   = $urandom_range(1, 9);
          mag = $urandom_range(pow10[d] - 1, pow10[d-1]);
          num = $urandom_range(0, 1) ? -mag : mag;
        end
        default: begin
          d   = $urandom_range(1, 9);
          mag = pow10[d] + $urandom_range(0, 4) - 2;
          num = $urandom_range(0, 1) ? -mag : mag;
        end
      endcase
      pending_values.push_back(num);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_values.size() != 0 || in_valid_i || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    // Leave time for any stray character to show up.
    repeat (40) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative), checked %0d characters.",
             numbers_sent, negatives_sent, chars_checked);
    $display("Longest text was %0d characters; %0d mismatches.", longest_text, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("Timed out with %0d characters still expected.", expected_text.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
